### rtl/pfc_pkg.sv
// ---------------------------------------------------------------------------
// pfc_pkg: shared types, constants and channel arithmetic
// Mode codes, field widths and the widen and narrow helpers that map a
// color field between a narrow range and eight bits
// ---------------------------------------------------------------------------
package pfc_pkg;

  localparam int PIXEL_W   = 32;
  localparam int MODE_W    = 3;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register index of the mode register
  localparam logic CFG_IDX_MODE = 1'b0;

  typedef enum logic [MODE_W-1:0] {
    MODE_565_TO_8888  = 3'd0,
    MODE_4444_TO_8888 = 3'd1,
    MODE_5551_TO_8888 = 3'd2,
    MODE_888_TO_RGBA  = 3'd3,
    MODE_888_TO_ARGB  = 3'd4,
    MODE_TO_565       = 3'd5,
    MODE_TO_4444      = 3'd6,
    MODE_TO_5551      = 3'd7
  } pfc_mode_t;

  localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;
  localparam logic [13:0] NARROW_BIAS  = 14'd127;

  // (v*255 + 15) / 31 split as 8v + (7v + 15) / 31, the small quotient by
  // reciprocal 265 / 2^13, exact for dividends up to 232
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [7:0]  y;
    logic [16:0] prod;
    y    = 8'({3'b000, v} * 8'd7) + 8'd15;
    prod = 17'({9'b0, y} * 17'd265);
    return 8'({v, 3'b000}) + 8'(prod[16:13]);
  endfunction

  // (v*255 + 31) / 63 split as 4v + (3v + 31) / 63, reciprocal 261 / 2^14
  function automatic logic [7:0] widen6(input logic [5:0] v);
    logic [7:0]  y;
    logic [16:0] prod;
    y    = 8'({2'b00, v} * 8'd3) + 8'd31;
    prod = 17'({9'b0, y} * 17'd261);
    return 8'({v, 2'b00}) + 8'(prod[16:14]);
  endfunction

  // (v*255 + 7) / 15 is exactly v*17
  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  // (v*m + 127) / 255 with the divide done as (x + x/256 + 1) / 256,
  // exact for x below 2^14
  function automatic logic [5:0] narrow8(input logic [7:0] v, input logic [5:0] m);
    logic [13:0] x;
    logic [13:0] s;
    x = 14'({6'b0, v} * {8'b0, m}) + NARROW_BIAS;
    s = x + {8'b0, x[13:8]} + 14'd1;
    return s[13:8];
  endfunction

endpackage

### rtl/pfc_if.sv
// ---------------------------------------------------------------------------
// pfc_if: pixel stream channels
// Valid/ready channels for the source pixel and the converted pixel
// ---------------------------------------------------------------------------
interface pfc_src_if;
  logic                        valid;
  logic                        ready;
  logic [pfc_pkg::PIXEL_W-1:0] source_pixel;

  modport source (output valid, output source_pixel, input ready);
  modport sink   (input valid, input source_pixel, output ready);
endinterface

interface pfc_dst_if;
  logic                        valid;
  logic                        ready;
  logic [pfc_pkg::PIXEL_W-1:0] dest_pixel;

  modport source (output valid, output dest_pixel, input ready);
  modport sink   (input valid, input dest_pixel, output ready);
endinterface

### rtl/pfc_convert.sv
// ---------------------------------------------------------------------------
// pfc_convert: pixel format conversion datapath
// Combinational conversion of one pixel for the selected mode
// ---------------------------------------------------------------------------
module pfc_convert (
  input  pfc_pkg::pfc_mode_t          mode,
  input  logic [pfc_pkg::PIXEL_W-1:0] src,
  output logic [pfc_pkg::PIXEL_W-1:0] dst
);

  // byte lanes of an 8888 source
  logic [7:0] r8, g8, b8, a8;
  assign r8 = src[7:0];
  assign g8 = src[15:8];
  assign b8 = src[23:16];
  assign a8 = src[31:24];

  // widened channels for the 16-bit sources
  logic [7:0] w565_r, w565_g, w565_b;
  logic [7:0] w4444_r, w4444_g, w4444_b, w4444_a;
  logic [7:0] w5551_r, w5551_g, w5551_b, w5551_a;

  assign w565_r  = pfc_pkg::widen5(src[15:11]);
  assign w565_g  = pfc_pkg::widen6(src[10:5]);
  assign w565_b  = pfc_pkg::widen5(src[4:0]);
  assign w4444_r = pfc_pkg::widen4(src[15:12]);
  assign w4444_g = pfc_pkg::widen4(src[11:8]);
  assign w4444_b = pfc_pkg::widen4(src[7:4]);
  assign w4444_a = pfc_pkg::widen4(src[3:0]);
  assign w5551_r = pfc_pkg::widen5(src[15:11]);
  assign w5551_g = pfc_pkg::widen5(src[10:6]);
  assign w5551_b = pfc_pkg::widen5(src[5:1]);
  assign w5551_a = src[0] ? pfc_pkg::ALPHA_OPAQUE : 8'h00;

  // narrowed channels for the 16-bit results
  logic [5:0] n_r5, n_g6, n_g5, n_b5, n_r4, n_g4, n_b4, n_a4;
  assign n_r5 = pfc_pkg::narrow8(r8, 6'd31);
  assign n_g6 = pfc_pkg::narrow8(g8, 6'd63);
  assign n_g5 = pfc_pkg::narrow8(g8, 6'd31);
  assign n_b5 = pfc_pkg::narrow8(b8, 6'd31);
  assign n_r4 = pfc_pkg::narrow8(r8, 6'd15);
  assign n_g4 = pfc_pkg::narrow8(g8, 6'd15);
  assign n_b4 = pfc_pkg::narrow8(b8, 6'd15);
  assign n_a4 = pfc_pkg::narrow8(a8, 6'd15);

  // result select, 16-bit results in the low half
  always_comb begin
    case (mode)
      pfc_pkg::MODE_565_TO_8888:  dst = {pfc_pkg::ALPHA_OPAQUE, w565_b, w565_g, w565_r};
      pfc_pkg::MODE_4444_TO_8888: dst = {w4444_a, w4444_b, w4444_g, w4444_r};
      pfc_pkg::MODE_5551_TO_8888: dst = {w5551_a, w5551_b, w5551_g, w5551_r};
      pfc_pkg::MODE_888_TO_RGBA:  dst = {pfc_pkg::ALPHA_OPAQUE, src[23:0]};
      pfc_pkg::MODE_888_TO_ARGB:  dst = {src[23:0], pfc_pkg::ALPHA_OPAQUE};
      pfc_pkg::MODE_TO_565:
        dst = {16'h0000, n_r5[4:0], n_g6[5:0], n_b5[4:0]};
      pfc_pkg::MODE_TO_4444:
        dst = {16'h0000, n_r4[3:0], n_g4[3:0], n_b4[3:0], n_a4[3:0]};
      pfc_pkg::MODE_TO_5551:
        dst = {16'h0000, n_r5[4:0], n_g5[4:0], n_b5[4:0], a8[7]};
      default: dst = '0;
    endcase
  end

endmodule

### rtl/pixel_format_converter_core.sv
// ---------------------------------------------------------------------------
// pixel_format_converter_core: streaming pixel format converter
// Converts one pixel a beat between packed formats chosen by a mode register
// ---------------------------------------------------------------------------
// path of a beat: input register, conversion logic, result register
// throughput of 1 pixel per cycle while out_ch.ready is high, set by the
//   two-stage valid/ready pipeline
// reset: synchronous active-low, clears both stage valids and sets mode to 0
module pixel_format_converter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  pfc_src_if.sink                        in_ch,
  pfc_dst_if.source                      out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pfc_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);

  // configuration register
  logic [pfc_pkg::MODE_W-1:0] mode_r;
  logic                       cfg_wr;
  logic                       cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[2] == pfc_pkg::CFG_IDX_MODE);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? {{(pfc_pkg::CFG_DATA_W-pfc_pkg::MODE_W){1'b0}}, mode_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= pfc_pkg::MODE_565_TO_8888;
    end else if (cfg_wr) begin
      mode_r <= pwdata[pfc_pkg::MODE_W-1:0];
    end
  end

  // stage handshake
  logic                        s1_valid_r;
  logic [pfc_pkg::PIXEL_W-1:0] s1_pixel_r;
  logic                        out_valid_r;
  logic [pfc_pkg::PIXEL_W-1:0] out_pixel_r;
  logic                        out_free;
  logic                        s1_free;
  logic                        in_beat;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_free     = !s1_valid_r || out_free;
  assign in_ch.ready = s1_free;
  assign in_beat     = in_ch.valid && s1_free;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_free) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_pixel_r <= in_ch.source_pixel;
    end
  end

  // conversion logic
  logic [pfc_pkg::PIXEL_W-1:0] conv_pixel;

  pfc_convert u_convert (
    .mode (pfc_pkg::pfc_mode_t'(mode_r)),
    .src  (s1_pixel_r),
    .dst  (conv_pixel)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_pixel_r <= conv_pixel;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.dest_pixel = out_pixel_r;

  // checks
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while both stages are full and stalled");

  a_beat_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> s1_valid_r)
    else $error("accepted beat did not reach the input register");

  a_stage_moves_on: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_free |=> out_valid_r)
    else $error("converted pixel lost between stages");

  a_narrow_high_zero: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && (mode_r == pfc_pkg::MODE_TO_565 || mode_r == pfc_pkg::MODE_TO_4444 ||
                   mode_r == pfc_pkg::MODE_TO_5551) |-> conv_pixel[31:16] == 16'h0000)
    else $error("16-bit result has nonzero upper half");

endmodule

### verif/pixel_conversion_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_conversion_checker: result checker for the pixel format converter
// Follows the mode register through the config port, works out the converted
// pixel for every source beat and compares each result beat in order; also
// checks the value read back from the mode register
// ---------------------------------------------------------------------------
module pixel_conversion_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  pfc_src_if                             in_ch,
  pfc_dst_if                             out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pfc_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] pwdata,
  input  logic [pfc_pkg::CFG_DATA_W-1:0] prdata,
  input  logic                           pready,
  output int                             fail_count
);

  localparam logic [pfc_pkg::CFG_ADDR_W-1:0] MODE_ADDR =
    pfc_pkg::CFG_ADDR_W'(4 * pfc_pkg::CFG_IDX_MODE);

  typedef struct {
    logic [pfc_pkg::PIXEL_W-1:0] source;
    pfc_pkg::pfc_mode_t          mode;
    logic [pfc_pkg::PIXEL_W-1:0] dest;
  } conversion_t;

  conversion_t        pending_pixels[$];
  pfc_pkg::pfc_mode_t active_mode = pfc_pkg::MODE_565_TO_8888;
  int                 mismatches = 0;
  int                 unanswered = 0;

  assign fail_count = mismatches + unanswered;

  // field of maximum maxv up to 8 bits, rounded
  function automatic logic [7:0] scale_up(input int unsigned v, input int unsigned maxv);
    return 8'((v * 255 + maxv / 2) / maxv);
  endfunction

  // 8-bit channel down to a field of maximum maxv, rounded
  function automatic int unsigned scale_down(input int unsigned v, input int unsigned maxv);
    return (v * maxv + 127) / 255;
  endfunction

  function automatic logic [pfc_pkg::PIXEL_W-1:0] converted_pixel(
    input pfc_pkg::pfc_mode_t mode, input logic [pfc_pkg::PIXEL_W-1:0] p);
    int unsigned r8, g8, b8, a8;
    r8 = p[7:0];
    g8 = p[15:8];
    b8 = p[23:16];
    a8 = p[31:24];
    case (mode)
      pfc_pkg::MODE_565_TO_8888:
        return {pfc_pkg::ALPHA_OPAQUE, scale_up(p[4:0], 31), scale_up(p[10:5], 63),
                scale_up(p[15:11], 31)};
      pfc_pkg::MODE_4444_TO_8888:
        return {scale_up(p[3:0], 15), scale_up(p[7:4], 15), scale_up(p[11:8], 15),
                scale_up(p[15:12], 15)};
      pfc_pkg::MODE_5551_TO_8888:
        return {(p[0] ? pfc_pkg::ALPHA_OPAQUE : 8'h00), scale_up(p[5:1], 31),
                scale_up(p[10:6], 31), scale_up(p[15:11], 31)};
      pfc_pkg::MODE_888_TO_RGBA:
        return {pfc_pkg::ALPHA_OPAQUE, p[23:0]};
      pfc_pkg::MODE_888_TO_ARGB:
        return {p[23:0], pfc_pkg::ALPHA_OPAQUE};
      pfc_pkg::MODE_TO_565:
        return {16'h0000, 5'(scale_down(r8, 31)), 6'(scale_down(g8, 63)),
                5'(scale_down(b8, 31))};
      pfc_pkg::MODE_TO_4444:
        return {16'h0000, 4'(scale_down(r8, 15)), 4'(scale_down(g8, 15)),
                4'(scale_down(b8, 15)), 4'(scale_down(a8, 15))};
      pfc_pkg::MODE_TO_5551:
        return {16'h0000, 5'(scale_down(r8, 31)), 5'(scale_down(g8, 31)),
                5'(scale_down(b8, 31)), 1'(scale_down(a8, 1))};
      default:
        return '0;
    endcase
  endfunction

  always @(posedge clk) begin
    conversion_t oldest;
    if (!rst_n) begin
      active_mode = pfc_pkg::MODE_565_TO_8888;
      pending_pixels.delete();
    end else begin
      // result beat against the oldest expectation
      if (out_ch.valid && out_ch.ready) begin
        if (pending_pixels.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat: expected none, got %h",
                   $time, out_ch.dest_pixel);
        end else begin
          oldest = pending_pixels.pop_front();
          if (out_ch.dest_pixel !== oldest.dest) begin
            mismatches++;
            $display("%0t: dest_pixel mismatch, mode %s source %h: expected %h, got %h",
                     $time, oldest.mode.name(), oldest.source, oldest.dest,
                     out_ch.dest_pixel);
          end
        end
      end

      // source beat
      if (in_ch.valid && in_ch.ready)
        pending_pixels.push_back('{source: in_ch.source_pixel, mode: active_mode,
                                   dest: converted_pixel(active_mode, in_ch.source_pixel)});

      // config access phase; other register indexes do nothing
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr == MODE_ADDR)
            active_mode = pfc_pkg::pfc_mode_t'(pwdata[pfc_pkg::MODE_W-1:0]);
        end else if (paddr == MODE_ADDR &&
                     prdata !== pfc_pkg::CFG_DATA_W'(active_mode)) begin
          mismatches++;
          $display("%0t: mode register readback: expected %h, got %h",
                   $time, pfc_pkg::CFG_DATA_W'(active_mode), prdata);
        end
      end
    end
    unanswered = pending_pixels.size();
  end

endmodule

### verif/pixel_format_converter_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// pixel_format_converter_core_test: testbench top for the pixel converter
// Sets each conversion mode over the config port, sends corner pixels and
// then random pixel phases with random gaps and stalls on both channels,
// including one long result stall; the checker judges every result beat
// ---------------------------------------------------------------------------
module pixel_format_converter_core_test;

  localparam logic [pfc_pkg::CFG_ADDR_W-1:0] MODE_ADDR   =
    pfc_pkg::CFG_ADDR_W'(4 * pfc_pkg::CFG_IDX_MODE);
  localparam logic [pfc_pkg::CFG_ADDR_W-1:0] UNUSED_ADDR =
    pfc_pkg::CFG_ADDR_W'(4 * (pfc_pkg::CFG_IDX_MODE + 1));
  localparam int RANDOM_PHASES  = 16;
  localparam int PRESSURE_PHASE = 3;
  localparam int HOLD_CYCLES    = 200;
  localparam int DRAIN_CYCLES   = 4;
  localparam int CYCLE_LIMIT    = 200000;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [pfc_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [pfc_pkg::CFG_DATA_W-1:0] pwdata = '0;
  logic [pfc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  int fail_count;
  int pixels_sent = 0;
  int results_taken = 0;
  int cycle_count = 0;
  int stall_left = 0;
  int steady_left = 0;
  int ready_roll;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;

  pfc_src_if pixel_in();
  pfc_dst_if pixel_out();

  pixel_format_converter_core DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (pixel_in),
    .out_ch  (pixel_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pixel_conversion_checker conv_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (pixel_in),
    .out_ch     (pixel_out),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fail_count (fail_count)
  );

  always #4 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("pixel_format_converter_core_test: FAIL");
      $finish;
    end
  end

  // result beats taken
  always @(posedge clk) begin
    if (rst_n && pixel_out.valid && pixel_out.ready)
      results_taken <= results_taken + 1;
  end

  // result side: random stalls, steady stretches and one long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      pixel_out.ready <= 1'b0;
    end else if (hold_request && !hold_done) begin
      pixel_out.ready <= 1'b0;
      hold_done = 1'b1;
      stall_left = HOLD_CYCLES;
    end else if (stall_left > 0) begin
      pixel_out.ready <= 1'b0;
      stall_left--;
    end else if (steady_left > 0) begin
      pixel_out.ready <= 1'b1;
      steady_left--;
    end else begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 5) begin
        pixel_out.ready <= 1'b1;
        steady_left = $urandom_range(30, 80);
      end else if (ready_roll < 75) begin
        pixel_out.ready <= 1'b1;
      end else if (ready_roll < 97) begin
        pixel_out.ready <= 1'b0;
        stall_left = $urandom_range(0, 2);
      end else begin
        pixel_out.ready <= 1'b0;
        stall_left = $urandom_range(10, 40);
      end
    end
  end

  // one config access, setup then access phase, then idle
  task automatic cfg_access(input bit is_write,
                            input logic [pfc_pkg::CFG_ADDR_W-1:0] addr,
                            input logic [pfc_pkg::CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // write a mode with random upper bits, then read it back
  task automatic set_mode(input pfc_pkg::pfc_mode_t mode);
    logic [pfc_pkg::CFG_DATA_W-1:0] data;
    data = $urandom;
    data[pfc_pkg::MODE_W-1:0] = mode;
    cfg_access(1'b1, MODE_ADDR, data);
    cfg_access(1'b0, MODE_ADDR, '0);
  endtask

  // one source beat, then a random gap unless steady
  task automatic send_pixel(input logic [pfc_pkg::PIXEL_W-1:0] pixel, input bit steady);
    int gap;
    int roll;
    pixel_in.valid        <= 1'b1;
    pixel_in.source_pixel <= pixel;
    do @(posedge clk); while (!pixel_in.ready);
    pixels_sent++;
    roll = $urandom_range(0, 99);
    if (steady || roll < 70)
      gap = 0;
    else if (roll < 95)
      gap = $urandom_range(1, 3);
    else
      gap = $urandom_range(8, 30);
    if (gap > 0) begin
      pixel_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every result is back
  task automatic finish_phase();
    pixel_in.valid <= 1'b0;
    while (results_taken != pixels_sent) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    pfc_pkg::pfc_mode_t          mode;
    logic [pfc_pkg::PIXEL_W-1:0] pixel;
    bit                          steady;
    int                          phase_items;

    pixel_in.valid        = 1'b0;
    pixel_in.source_pixel = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // corner pixels per mode; mode 0 runs from its reset value
    for (int m = 0; m < 8; m++) begin
      mode = pfc_pkg::pfc_mode_t'(m);
      if (mode != pfc_pkg::MODE_565_TO_8888)
        set_mode(mode);
      else
        cfg_access(1'b0, MODE_ADDR, '0);
      send_pixel(32'h0000_0000, 1'b0);
      send_pixel(32'hFFFF_FFFF, 1'b0);
      case (mode)
        // upper half of a 16-bit source is ignored
        pfc_pkg::MODE_565_TO_8888,
        pfc_pkg::MODE_4444_TO_8888: send_pixel(32'hFFFF_0000, 1'b0);
        pfc_pkg::MODE_5551_TO_8888: send_pixel(32'hFFFF_0001, 1'b0);
        // top byte of an rgb888 source is ignored
        pfc_pkg::MODE_888_TO_RGBA,
        pfc_pkg::MODE_888_TO_ARGB:  send_pixel(32'hFF00_0000, 1'b0);
        pfc_pkg::MODE_TO_565:       send_pixel(32'h0080_7F80, 1'b0);
        pfc_pkg::MODE_TO_4444:      send_pixel(32'h807F_8008, 1'b0);
        pfc_pkg::MODE_TO_5551: begin
          // alpha bit threshold on both sides of 128
          send_pixel(32'h807F_7F80, 1'b0);
          send_pixel(32'h7F80_8080, 1'b0);
        end
        default: ;
      endcase
      finish_phase();
    end

    // write to an unused register index leaves the mode alone
    cfg_access(1'b1, UNUSED_ADDR, $urandom);
    cfg_access(1'b0, MODE_ADDR, '0);

    // random phases: every mode first, then random modes
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      mode = (p < 8) ? pfc_pkg::pfc_mode_t'(p) : pfc_pkg::pfc_mode_t'($urandom_range(0, 7));
      set_mode(mode);
      if ($urandom_range(0, 9) < 3)
        cfg_access(1'b1, UNUSED_ADDR, $urandom);
      steady = (p == PRESSURE_PHASE) || ($urandom_range(0, 3) == 0);
      if (p == PRESSURE_PHASE)
        hold_request = 1'b1;
      phase_items = $urandom_range(20, 48);
      for (int i = 0; i < phase_items; i++) begin
        if ($urandom_range(0, 2) == 0) begin
          pixel = $urandom;
        end else begin
          // bytes biased toward rounding edges and extremes
          for (int k = 0; k < 4; k++) begin
            case ($urandom_range(0, 4))
              0:       pixel[8*k +: 8] = 8'h00;
              1:       pixel[8*k +: 8] = 8'hFF;
              2:       pixel[8*k +: 8] = 8'h7F;
              3:       pixel[8*k +: 8] = 8'h80;
              default: pixel[8*k +: 8] = 8'($urandom);
            endcase
          end
        end
        send_pixel(pixel, steady);
      end
      finish_phase();
    end

    if (fail_count == 0)
      $display("pixel_format_converter_core_test: PASS");
    else
      $display("pixel_format_converter_core_test: FAIL");
    $finish;
  end

endmodule
